FILE: rtl/core/lattice_basis_structure_factor_core_macros.svh
// assertion macros for the lattice basis structure factor core
// used by lattice_basis_structure_factor_core.sv, no other dependencies
`ifndef LATTICE_BASIS_STRUCTURE_FACTOR_CORE_MACROS_SVH
`define LATTICE_BASIS_STRUCTURE_FACTOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LBSF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lbsf assertion failed");
`define LBSF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lbsf assertion failed");
`else
`define LBSF_ASSERT(lbl, clk, rst, prop)
`define LBSF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/lbsf_pkg.sv
// types, constants and trig table builder for the structure factor core
// no dependencies
`default_nettype none
package lbsf_pkg;

   localparam int CMD_W    = 2;
   localparam int POS_W    = 20;
   localparam int IDX_W    = 6;
   localparam int MIL_W    = 8;
   localparam int STAT_W   = 2;
   localparam int COUNT_W  = 7;
   localparam int SUM_W    = 22;
   localparam int TRIG_W   = 16;
   localparam int PHASE_W  = 16;
   localparam int REQ_W    = 96;
   localparam int RSP_W    = 120;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FACTOR = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_ITEM = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 22'sh1FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -22'sh200000;

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

   localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210, 64'd272};
   localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                           64'd90, 64'd132, 64'd182, 64'd240};

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_ADD, ST_RD_ISSUE, ST_RD_WAIT, ST_DEL_RD, ST_DEL_CHK,
      ST_SF_RD, ST_SF_M0, ST_SF_M1, ST_SF_M2, ST_SF_LK, ST_SF_ACC, ST_OUT
   } state_type;

   // clamp a series sum to [0, 1.0] in q30 and round to q14
   function automatic logic signed [TRIG_W-1:0] lbsf_q14(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = v;
      if (c < 0) c = 0;
      if (c > $signed(ONE_Q30)) c = $signed(ONE_Q30);
      return TRIG_W'((c + 64'sd32768) >>> 16);
   endfunction

   // returns {cos, sin} in q1.14 for table entry idx of a 2^bits table
   function automatic logic [2*TRIG_W-1:0] lbsf_trig(input int unsigned idx,
                                                     input int unsigned bits);
      logic [63:0] quarter, q, r, a, a2, t;
      logic signed [63:0] ss, cs;
      logic signed [TRIG_W-1:0] s16, c16, co, si;
      quarter = 64'd1 << (bits - 2);
      q  = (64'(idx) >> (bits - 2)) & 64'd3;
      r  = 64'(idx) & (quarter - 64'd1);
      a  = (r * TWO_PI_Q30) >> bits;
      a2 = (a * a) >> 30;
      t  = a;
      ss = $signed(a);
      for (int n = 0; n < 8; n++) begin
         t = ((t * a2) >> 30) / SIN_DIV[n];
         if (n % 2 == 0) ss = ss - $signed(t);
         else ss = ss + $signed(t);
      end
      t  = ONE_Q30;
      cs = $signed(ONE_Q30);
      for (int n = 0; n < 8; n++) begin
         t = ((t * a2) >> 30) / COS_DIV[n];
         if (n % 2 == 0) cs = cs - $signed(t);
         else cs = cs + $signed(t);
      end
      s16 = lbsf_q14(ss);
      c16 = lbsf_q14(cs);
      unique case (q[1:0])
         2'd0: begin co = c16;  si = s16;  end
         2'd1: begin co = -s16; si = c16;  end
         2'd2: begin co = -c16; si = -s16; end
         default: begin co = s16; si = -c16; end
      endcase
      return {co, si};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lattice_basis_structure_factor_core.sv
// top level: atom basis table and structure factor sequencer
// depends on lbsf_pkg, lbsf_ram and the assertion macro header
//
// usage: one request beat on req_* carries a command; exactly one response
// beat on rsp_* follows. req_tready is high only while the block is idle,
// and the block holds the response until rsp_tready takes it, then becomes
// ready again. commands: add an atom, read an entry, delete matching atoms,
// structure factor. the atom walk reads one table entry at a time through
// the ram read port; the phase of each atom goes through one shared 8x20
// multiplier in three steps, then one registered cos/sin table lookup and
// one accumulate. after reset the block writes the origin atom to entry 0
// and then accepts requests with a count of one. while the receiver stalls
// the response beat stays on rsp_tdata and no request is taken.
`default_nettype none
`include "lattice_basis_structure_factor_core_macros.svh"
module lattice_basis_structure_factor_core #(
   parameter int MAX_ATOMS        = 64,
   parameter int PHASE_TABLE_BITS = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // cmd, pos_x, pos_y, pos_z, entry_index, miller_h, miller_k, miller_l
   input  wire logic [lbsf_pkg::REQ_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // status, atom_count, out_x, out_y, out_z, factor_real, factor_imag
   output logic      [lbsf_pkg::RSP_W-1:0] rsp_tdata
);
   import lbsf_pkg::*;

   localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int CW    = $clog2(MAX_ATOMS + 1);
   localparam int ACC_W = CW + TRIG_W + 1;
   localparam int TSIZE = 1 << PHASE_TABLE_BITS;
   localparam int ENT_W = 3 * POS_W;

   state_type state_ff, state_in;
   logic [CW-1:0] total_ff, total_in, i_ff, i_in, w_ff, w_in;
   logic [ENT_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic signed [MIL_W-1:0] h_ff, h_in, k_ff, k_in, l_ff, l_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [2*TRIG_W-1:0] trig_ff, trig_in;
   logic signed [ACC_W-1:0] fr_ff, fr_in, fi_ff, fi_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [ENT_W-1:0] out_pos_ff, out_pos_in;
   logic signed [SUM_W-1:0] ofr_ff, ofr_in, ofi_ff, ofi_in;

   logic wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [ENT_W-1:0] wr_data, rd_data;

   logic signed [MIL_W-1:0] mul_a;
   logic signed [POS_W-1:0] mul_b;
   logic signed [MIL_W+POS_W-1:0] prod;

   logic [2*TRIG_W-1:0] trig_rom [TSIZE];

   for (genvar g = 0; g < TSIZE; g++) begin : g_rom
      assign trig_rom[g] = lbsf_trig(g, PHASE_TABLE_BITS);
   end

   lbsf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ATOMS)) u_atoms (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign prod = mul_a * mul_b;

   function automatic logic signed [SUM_W-1:0] sat(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(SUM_MAX)) return SUM_MAX;
      if (v < ACC_W'(SUM_MIN)) return SUM_MIN;
      return SUM_W'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         total_ff <= CW'(1);
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
      i_ff <= i_in;
      w_ff <= w_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      h_ff <= h_in;
      k_ff <= k_in;
      l_ff <= l_in;
      phase_ff <= phase_in;
      trig_ff <= trig_in;
      fr_ff <= fr_in;
      fi_ff <= fi_in;
      stat_ff <= stat_in;
      out_pos_ff <= out_pos_in;
      ofr_ff <= ofr_in;
      ofi_ff <= ofi_in;
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      i_in = i_ff;
      w_in = w_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      h_in = h_ff;
      k_in = k_ff;
      l_in = l_ff;
      phase_in = phase_ff;
      trig_in = trig_ff;
      fr_in = fr_ff;
      fi_in = fi_ff;
      stat_in = stat_ff;
      out_pos_in = out_pos_ff;
      ofr_in = ofr_ff;
      ofi_in = ofi_ff;
      wr_en = 1'b0;
      wr_addr = i_ff[AW-1:0];
      wr_data = pos_ff;
      rd_en = 1'b0;
      rd_addr = i_ff[AW-1:0];
      mul_a = h_ff;
      mul_b = rd_data[POS_W-1:0];
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data = '0;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pos_in = req_tdata[61:2];
               idx_in = req_tdata[67:62];
               h_in = req_tdata[75:68];
               k_in = req_tdata[83:76];
               l_in = req_tdata[91:84];
               i_in = '0;
               w_in = '0;
               fr_in = '0;
               fi_in = '0;
               stat_in = STAT_OK;
               out_pos_in = '0;
               ofr_in = '0;
               ofi_in = '0;
               unique case (req_tdata[1:0])
                  CMD_ADD: state_in = ST_ADD;
                  CMD_DELETE: state_in = ST_DEL_RD;
                  CMD_READ: state_in = ST_RD_ISSUE;
                  default: state_in = ST_SF_RD;
               endcase
            end
         end
         ST_ADD: begin
            if (32'(total_ff) >= 32'(MAX_ATOMS)) begin
               stat_in = STAT_FULL;
            end else begin
               wr_en = 1'b1;
               wr_addr = total_ff[AW-1:0];
               total_in = total_ff + CW'(1);
            end
            state_in = ST_OUT;
         end
         ST_RD_ISSUE: begin
            rd_addr = AW'(idx_ff);
            if (32'(idx_ff) < 32'(total_ff)) begin
               rd_en = 1'b1;
               state_in = ST_RD_WAIT;
            end else begin
               stat_in = STAT_NO_ITEM;
               state_in = ST_OUT;
            end
         end
         ST_RD_WAIT: begin
            out_pos_in = rd_data;
            state_in = ST_OUT;
         end
         ST_DEL_RD: begin
            if (i_ff < total_ff) begin
               rd_en = 1'b1;
               state_in = ST_DEL_CHK;
            end else begin
               total_in = w_ff;
               state_in = ST_OUT;
            end
         end
         ST_DEL_CHK: begin
            if (rd_data != pos_ff) begin
               wr_en = 1'b1;
               wr_addr = w_ff[AW-1:0];
               wr_data = rd_data;
               w_in = w_ff + CW'(1);
            end
            i_in = i_ff + CW'(1);
            state_in = ST_DEL_RD;
         end
         ST_SF_RD: begin
            if (i_ff < total_ff) begin
               rd_en = 1'b1;
               state_in = ST_SF_M0;
            end else begin
               ofr_in = sat(fr_ff);
               ofi_in = sat(fi_ff);
               state_in = ST_OUT;
            end
         end
         ST_SF_M0: begin
            phase_in = prod[PHASE_W-1:0];
            state_in = ST_SF_M1;
         end
         ST_SF_M1: begin
            mul_a = k_ff;
            mul_b = rd_data[2*POS_W-1:POS_W];
            phase_in = phase_ff + prod[PHASE_W-1:0];
            state_in = ST_SF_M2;
         end
         ST_SF_M2: begin
            mul_a = l_ff;
            mul_b = rd_data[3*POS_W-1:2*POS_W];
            phase_in = phase_ff + prod[PHASE_W-1:0];
            state_in = ST_SF_LK;
         end
         ST_SF_LK: begin
            trig_in = trig_rom[phase_ff[PHASE_W-1 -: PHASE_TABLE_BITS]];
            state_in = ST_SF_ACC;
         end
         ST_SF_ACC: begin
            fr_in = fr_ff + ACC_W'($signed(trig_ff[2*TRIG_W-1:TRIG_W]));
            fi_in = fi_ff + ACC_W'($signed(trig_ff[TRIG_W-1:0]));
            i_in = i_ff + CW'(1);
            state_in = ST_SF_RD;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = {7'd0, ofi_ff, ofr_ff, out_pos_ff, COUNT_W'(total_ff), stat_ff};

   `LBSF_ASSERT(a_count_bound, clock, reset, 32'(total_ff) <= 32'(MAX_ATOMS))
   `LBSF_ASSERT(a_ready_excl, clock, reset, !(req_tready && rsp_tvalid))
   `LBSF_ASSERT(a_compact_order, clock, reset, state_ff == ST_DEL_CHK |-> w_ff <= i_ff)
   `LBSF_ASSERT(a_wr_in_range, clock, reset,
      wr_en && state_ff != ST_INIT |-> 32'(wr_addr) < 32'(MAX_ATOMS))
endmodule
`default_nettype wire

FILE: rtl/core/lbsf_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module lbsf_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire
